// ----- rtl/gif_lzw_code_stream_encoder_assert.svh -----
// Assertion macros for the GIF LZW code stream encoder checker.
// Needs signals clk and arst_n in the scope that uses them.
`ifndef GIF_LZW_CODE_STREAM_ENCODER_ASSERT_SVH
`define GIF_LZW_CODE_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define GLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is low.
`define GLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gle_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the GIF LZW code stream encoder.
// No dependencies; used by every module of the block.
package gle_pkg;

	localparam int CODE_DEPTH_DEF = 7;
	localparam int DICT_ENTRIES   = 4096;
	localparam int CODE_W         = 12;
	localparam int WIDTH_W        = 4;
	localparam int PIX_PORT_W     = 7;
	localparam logic [CODE_W-1:0] FLUSH_AT = 12'hfff;

	typedef struct packed {
		logic [PIX_PORT_W-1:0] pixel_index;
		logic                  end_of_image;
	} px_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} cs_item_t;

	// Code handed from the dictionary sequencer to the bit packer.
	typedef struct packed {
		logic               valid;
		logic [CODE_W-1:0]  code;
		logic [WIDTH_W-1:0] width;
		logic               final_code;
	} pack_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OPEN,
		ST_ROOT,
		ST_WALK,
		ST_PFX,
		ST_ADD,
		ST_LINK,
		ST_FLUSH,
		ST_LAST_PFX,
		ST_EOI
	} seq_state_t;

endpackage

// ----- rtl/gle_packer.sv -----
`timescale 1ns / 1ps
// Bit packer: gathers variable width codes LSB first and drains bytes.
// Depends on gle_pkg.
module gle_packer (
	input  logic               clk,
	input  logic               arst_n,
	input  gle_pkg::pack_cmd_t cmd,
	output logic               cmd_ready,
	output logic               cs_valid,
	input  logic               cs_ready,
	output gle_pkg::cs_item_t  cs_item
);
	import gle_pkg::*;

	localparam int ACC_W = CODE_W + 7;

	logic [ACC_W-1:0]  acc_q;
	logic [4:0]        cnt_q;
	logic              final_q;
	logic              put_ok;
	logic              byte_load;
	logic [CODE_W-1:0] code_m;
	logic [CODE_W:0]   mask;

	assign cmd_ready = (cnt_q < 5'd8) && !final_q;
	assign put_ok    = !cs_valid || cs_ready;
	assign byte_load = put_ok && ((cnt_q >= 5'd8) || final_q);
	assign mask      = (13'd1 << cmd.width) - 13'd1;
	assign code_m    = cmd.code & mask[CODE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			final_q  <= 1'b0;
			cs_valid <= 1'b0;
		end else begin
			if (byte_load)
				cs_valid <= 1'b1;
			else if (cs_ready)
				cs_valid <= 1'b0;
			if (cmd.valid && cmd_ready) begin
				acc_q   <= acc_q | (ACC_W'(code_m) << cnt_q);
				cnt_q   <= cnt_q + 5'(cmd.width);
				final_q <= cmd.final_code;
			end else if (put_ok && cnt_q >= 5'd8) begin
				cs_item.data_byte <= acc_q[7:0];
				cs_item.last_byte <= final_q && (cnt_q == 5'd8);
				if (cnt_q == 5'd8)
					final_q <= 1'b0;
				acc_q <= acc_q >> 8;
				cnt_q <= cnt_q - 5'd8;
			end else if (put_ok && final_q) begin
				// pad the tail byte with zeros
				cs_item.data_byte <= acc_q[7:0];
				cs_item.last_byte <= 1'b1;
				acc_q   <= '0;
				cnt_q   <= '0;
				final_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/gle_dict_seq.sv -----
`timescale 1ns / 1ps
// Dictionary sequencer: child/sibling chain walk, entry append and code issue.
// Depends on gle_pkg; holds the three dictionary memories.
module gle_dict_seq #(
	parameter int CODE_DEPTH = gle_pkg::CODE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               px_valid,
	output logic               px_ready,
	input  gle_pkg::px_item_t  px_item,
	output gle_pkg::pack_cmd_t cmd,
	input  logic               cmd_ready
);
	import gle_pkg::*;

	localparam int ROOT_COUNT = 1 << CODE_DEPTH;
	localparam int PIX_W = (CODE_DEPTH < PIX_PORT_W) ? CODE_DEPTH : PIX_PORT_W;
	localparam logic [CODE_W-1:0] CLEAR_CODE = CODE_W'(1 << CODE_DEPTH);
	localparam logic [CODE_W-1:0] EOI_CODE   = CLEAR_CODE + CODE_W'(1);
	localparam logic [CODE_W-1:0] FIRST_FREE = CLEAR_CODE + CODE_W'(2);
	localparam logic [WIDTH_W-1:0] START_W   = WIDTH_W'(CODE_DEPTH + 1);

	seq_state_t state_q, state_d;

	logic [PIX_W-1:0]      pix_q;
	logic                  last_q;
	logic [CODE_W-1:0]     prefix_q, nfc_q, cur_q, tail_q;
	logic [WIDTH_W-1:0]    width_q;
	logic                  open_q, has_tail_q;
	logic [ROOT_COUNT-1:0] root_vld_q;

	logic [CODE_W-1:0] fc_mem [DICT_ENTRIES];
	logic [CODE_W-1:0] ns_mem [DICT_ENTRIES];
	logic [PIX_W-1:0]  ep_mem [DICT_ENTRIES];
	logic [CODE_W-1:0] fc_rd_q, ns_rd_q;
	logic [PIX_W-1:0]  ep_rd_q;

	logic              is_root, root_ok, accept, hit;
	logic [CODE_W-1:0] first_c, rd_addr, nfc_inc;
	logic              fc_we, ns_we, ep_we;
	logic [CODE_W-1:0] fc_wa, fc_wd, ns_wa, ns_wd;

	assign accept  = px_valid && px_ready;
	assign is_root = (prefix_q >> CODE_DEPTH) == '0;
	assign root_ok = !is_root || root_vld_q[prefix_q[CODE_DEPTH-1:0]];
	assign first_c = root_ok ? fc_rd_q : '0;
	assign hit     = (ep_rd_q == pix_q);
	assign rd_addr = (state_q == ST_ROOT) ? first_c : ns_rd_q;
	assign nfc_inc = nfc_q + CODE_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (accept)
					state_d = open_q ? ST_ROOT : ST_OPEN;
			ST_OPEN:
				if (cmd_ready)
					state_d = last_q ? ST_LAST_PFX : ST_IDLE;
			ST_ROOT:
				state_d = (first_c == '0) ? ST_PFX : ST_WALK;
			ST_WALK:
				if (hit)
					state_d = last_q ? ST_LAST_PFX : ST_IDLE;
				else if (ns_rd_q == '0)
					state_d = ST_PFX;
			ST_PFX:
				if (cmd_ready)
					state_d = ST_ADD;
			ST_ADD:
				state_d = ST_LINK;
			ST_LINK:
				if (nfc_inc == FLUSH_AT)
					state_d = ST_FLUSH;
				else
					state_d = last_q ? ST_LAST_PFX : ST_IDLE;
			ST_FLUSH:
				if (cmd_ready)
					state_d = last_q ? ST_LAST_PFX : ST_IDLE;
			ST_LAST_PFX:
				if (cmd_ready)
					state_d = ST_EOI;
			ST_EOI:
				if (cmd_ready)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// outputs: code commands and memory writes
	always_comb begin
		px_ready = 1'b0;
		cmd      = '0;
		cmd.width = width_q;
		fc_we = 1'b0; fc_wa = nfc_q; fc_wd = '0;
		ns_we = 1'b0; ns_wa = nfc_q; ns_wd = '0;
		ep_we = 1'b0;
		case (state_q)
			ST_IDLE:     px_ready = 1'b1;
			ST_OPEN:     begin cmd.valid = 1'b1; cmd.code = CLEAR_CODE; end
			ST_FLUSH:    begin cmd.valid = 1'b1; cmd.code = CLEAR_CODE; end
			ST_PFX:      begin cmd.valid = 1'b1; cmd.code = prefix_q; end
			ST_LAST_PFX: begin cmd.valid = 1'b1; cmd.code = prefix_q; end
			ST_EOI: begin
				cmd.valid      = 1'b1;
				cmd.code       = EOI_CODE;
				cmd.final_code = 1'b1;
			end
			ST_ADD: begin
				fc_we = 1'b1;
				ns_we = 1'b1;
				ep_we = 1'b1;
			end
			ST_LINK: begin
				if (has_tail_q) begin
					ns_we = 1'b1; ns_wa = tail_q; ns_wd = nfc_q;
				end else begin
					fc_we = 1'b1; fc_wa = prefix_q; fc_wd = nfc_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fc_we)
			fc_mem[fc_wa] <= fc_wd;
		if (ns_we)
			ns_mem[ns_wa] <= ns_wd;
		if (ep_we)
			ep_mem[nfc_q] <= pix_q;
		fc_rd_q <= fc_mem[prefix_q];
		ns_rd_q <= ns_mem[rd_addr];
		ep_rd_q <= ep_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prefix_q   <= '0;
			width_q    <= START_W;
			nfc_q      <= FIRST_FREE;
			open_q     <= 1'b0;
			has_tail_q <= 1'b0;
			root_vld_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE:
					if (accept) begin
						pix_q  <= px_item.pixel_index[PIX_W-1:0];
						last_q <= px_item.end_of_image;
						if (!open_q) begin
							root_vld_q <= '0;
							width_q    <= START_W;
							nfc_q      <= FIRST_FREE;
							prefix_q   <= CODE_W'(px_item.pixel_index[PIX_W-1:0]);
							open_q     <= 1'b1;
						end
					end
				ST_ROOT: begin
					cur_q      <= first_c;
					has_tail_q <= 1'b0;
				end
				ST_WALK:
					if (hit) begin
						prefix_q <= cur_q;
					end else if (ns_rd_q == '0) begin
						tail_q     <= cur_q;
						has_tail_q <= 1'b1;
					end else begin
						cur_q <= ns_rd_q;
					end
				ST_LINK: begin
					if (!has_tail_q && is_root)
						root_vld_q[prefix_q[CODE_DEPTH-1:0]] <= 1'b1;
					if (width_q < 4'd15 && {4'b0, nfc_q} == (16'd1 << width_q))
						width_q <= width_q + WIDTH_W'(1);
					nfc_q    <= nfc_inc;
					prefix_q <= CODE_W'(pix_q);
				end
				ST_FLUSH:
					if (cmd_ready) begin
						root_vld_q <= '0;
						width_q    <= START_W;
						nfc_q      <= FIRST_FREE;
					end
				ST_EOI:
					if (cmd_ready)
						open_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/gif_lzw_code_stream_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the GIF LZW code stream encoder.
// Depends on gle_pkg, gle_dict_seq and gle_packer.
//
//  channel | role   | handshake            | payload
//  --------+--------+----------------------+--------------------------------
//  px      | input  | px_valid / px_ready  | px_item (pixel_index, end_of_image)
//  cs      | output | cs_valid / cs_ready  | cs_item (data_byte, last_byte)
//
// A pixel whose string is found at the head of a chain passes the idle, root and
// walk states, with a walk step per sibling link (one dictionary memory read per
// cycle); a miss then issues the prefix code, writes the entry and links it, a
// flush adds a clear code, the first pixel of an image just issues a clear code
// and the last pixel adds its final codes. Each code waits until the
// packer holds fewer than 8 bits, so bytes drain at one per cycle while cs is not stalled.
// Reset clears the sequencer, the packer and the root valid bits; no memory
// sweep is needed. A stall on cs holds the byte register and backs up codes.
module gif_lzw_code_stream_encoder #(
	parameter int CODE_DEPTH = gle_pkg::CODE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              px_valid,
	output logic              px_ready,
	input  gle_pkg::px_item_t px_item,
	output logic              cs_valid,
	input  logic              cs_ready,
	output gle_pkg::cs_item_t cs_item
);
	import gle_pkg::*;

	pack_cmd_t cmd;
	logic      cmd_ready;

	// walk the dictionary and issue codes
	gle_dict_seq #(
		.CODE_DEPTH(CODE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.px_valid (px_valid),
		.px_ready (px_ready),
		.px_item  (px_item),
		.cmd      (cmd),
		.cmd_ready(cmd_ready)
	);

	// pack codes LSB first into the byte stream
	gle_packer u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_ready(cmd_ready),
		.cs_valid (cs_valid),
		.cs_ready (cs_ready),
		.cs_item  (cs_item)
	);

endmodule

// ----- rtl/gle_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the GIF LZW code stream encoder, with its bind.
// Depends on gle_pkg and gif_lzw_code_stream_encoder_assert.svh.
`include "gif_lzw_code_stream_encoder_assert.svh"

module gle_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              px_valid,
	input logic              px_ready,
	input logic              cs_valid,
	input logic              cs_ready,
	input gle_pkg::cs_item_t cs_item
);
	// a stalled output byte must hold
	`GLE_ASSERT_NEXT(a_cs_hold, cs_valid && !cs_ready, cs_valid && $stable(cs_item), "cs stall")
	// an accepted pixel always keeps the block busy for the next cycle
	`GLE_ASSERT_NEXT(a_busy_after_take, px_valid && px_ready, !px_ready, "ready after take")
	// ready drops only because a pixel was taken
	`GLE_ASSERT_NOW(a_drop_cause, $fell(px_ready), $past(px_valid && px_ready), "ready drop")

endmodule

bind gif_lzw_code_stream_encoder gle_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.px_valid(px_valid),
	.px_ready(px_ready),
	.cs_valid(cs_valid),
	.cs_ready(cs_ready),
	.cs_item (cs_item)
);
